// ----- rtl/matrix_inverse_3x3_top_assert.svh -----
// assertion macros for the matrix inverse block
`ifndef MATRIX_INVERSE_3X3_TOP_ASSERT_SVH
`define MATRIX_INVERSE_3X3_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define MI_ASSERT_IMPL(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define MI_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define MI_ASSERT_IMPL(lbl, clk, rst_n, a, c)
`define MI_ASSERT_NEXT(lbl, clk, rst_n, a, c)
`endif
`endif

// ----- rtl/mi3_pkg.sv -----
package mi3_pkg;
    localparam int ElemW = 32;
    localparam int FracB = 16;
    localparam int ProdW = 2 * ElemW;
    localparam int CofW  = 2 * ElemW + 1;
    localparam int DetW  = 3 * ElemW + 3;
    localparam int BitsPerStage = 4;
    // numerator padded with leading zeros to whole divider stages
    localparam int NumW  = ((CofW + 2 * FracB + BitsPerStage - 1) / BitsPerStage)
                           * BitsPerStage;
    localparam int QW    = NumW;
    localparam int DivStages = (QW + BitsPerStage - 1) / BitsPerStage;
    localparam logic [QW-1:0] SatLim = QW'(1) << (ElemW - 1);

    typedef logic signed [ElemW-1:0] t_elem;
    typedef logic signed [CofW-1:0]  t_cof;
    typedef logic signed [DetW-1:0]  t_det;

    typedef struct packed {
        logic [NumW-1:0] rem;
        logic [NumW-1:0] num;
        logic [QW-1:0]   quo;
    } t_div_lane;

    typedef struct packed {
        logic singular;
        logic [8:0] neg;
    } t_side;
endpackage

// ----- rtl/matrix_inverse_3x3_top.sv -----
// 3x3 fixed-point matrix inverse, Q16.16, by the adjugate
// s_axis: one word per matrix, tdata holds r0c0..r2c2 from the lowest bit,
// 32 bits each. m_axis: one word per inverse, tdata holds inv r0c0..r2c2
// then the singular and saturated flags, padded to whole bytes.
// fully pipelined: one matrix per cycle sustained unless the output stalls. the
// stages are the cofactor multipliers (3), determinant (3), the restoring divider at
// 4 quotient bits per stage (1 + 25) and the saturation stage (1).
// a zero determinant gives singular set and all-zero elements.
// reset clears the valid bits only. when a word waits at the output and
// m_axis_tready is low the whole pipeline holds; a skid register keeps
// s_axis_tready free of the downstream combinational path.
`include "matrix_inverse_3x3_top_assert.svh"
module matrix_inverse_3x3_top
    import mi3_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [287:0] s_axis_tdata,  // r0c0 r0c1 r0c2 r1c0 r1c1 r1c2 r2c0 r2c1 r2c2
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [295:0] m_axis_tdata   // inv r0c0..r2c2, singular, saturated
);
    localparam int Lat = 3 + 3 + DivStages + 2;
    logic [Lat-1:0] r_v;
    logic en;
    logic r_sk_v;
    logic [287:0] r_sk;
    logic in_v;
    logic [287:0] in_d;
    t_elem a [9];
    t_cof  cof [9];
    t_elem a0 [3];
    t_det  det;
    t_cof  cof2 [9];
    logic [QW-1:0] quo [9];
    t_side side;
    logic [295:0] r_out;
    logic [295:0] n_out;
    logic sat;
    logic [ElemW-1:0] e;

    assign en = !r_v[Lat-1] || m_axis_tready;
    assign s_axis_tready = !r_sk_v;
    assign in_v = r_sk_v || s_axis_tvalid;
    assign in_d = r_sk_v ? r_sk : s_axis_tdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sk_v <= 1'b0;
            r_v <= '0;
        end else begin
            if (en) begin
                r_sk_v <= 1'b0;
                r_v <= {r_v[Lat-2:0], in_v};
            end else if (s_axis_tvalid && !r_sk_v) begin
                r_sk_v <= 1'b1;
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (!en && s_axis_tvalid && !r_sk_v) r_sk <= s_axis_tdata;
    end

    always_comb begin
        for (int k = 0; k < 9; k++) a[k] = in_d[k*ElemW +: ElemW];
    end

    mi3_cof u_cof (.i_clk(i_clk), .i_en(en), .i_a(a), .o_cof(cof), .o_a0(a0));
    mi3_det u_det (.i_clk(i_clk), .i_en(en), .i_cof(cof), .i_a0(a0),
                   .o_det(det), .o_cof(cof2));
    mi3_div u_div (.i_clk(i_clk), .i_en(en), .i_det(det), .i_cof(cof2),
                   .o_quo(quo), .o_side(side));

    always_comb begin
        n_out = '0;
        sat = 1'b0;
        for (int k = 0; k < 9; k++) begin
            if (side.neg[k] ? (quo[k] > SatLim)
                            : (quo[k] >= SatLim)) begin
                sat = 1'b1;
                e = side.neg[k] ? {1'b1, {(ElemW-1){1'b0}}} : {1'b0, {(ElemW-1){1'b1}}};
            end else begin
                e = side.neg[k] ? -quo[k][ElemW-1:0] : quo[k][ElemW-1:0];
            end
            n_out[k*ElemW +: ElemW] = side.singular ? '0 : e;
        end
        n_out[9*ElemW]   = side.singular;
        n_out[9*ElemW+1] = sat && !side.singular;
    end

    always_ff @(posedge i_clk) begin
        if (en) r_out <= n_out;
    end

    assign m_axis_tvalid = r_v[Lat-1];
    assign m_axis_tdata  = r_out;

    `MI_ASSERT_IMPL(a_flags_excl, i_clk, i_rst_n, m_axis_tvalid,
        !(m_axis_tdata[288] && m_axis_tdata[289]))
    `MI_ASSERT_IMPL(a_sing_zero, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[288],
        m_axis_tdata[287:0] == '0)
    `MI_ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata))
endmodule

// ----- rtl/mi3_cof.sv -----
module mi3_cof
    import mi3_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_en,
    input  t_elem           i_a [9],
    output t_cof            o_cof [9],
    output t_elem           o_a0 [3]
);
    t_elem r_a [9];
    logic signed [ProdW-1:0] r_p [18];
    t_elem r_a0 [3];
    t_cof  r_c [9];
    t_elem r_a0b [3];

    function automatic int idx(input int r, input int c);
        return r * 3 + c;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a <= i_a;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_p[2*idx(i,j)] <= r_a[idx((i==0)?1:0, (j==0)?1:0)]
                                     * r_a[idx((i==2)?1:2, (j==2)?1:2)];
                    r_p[2*idx(i,j)+1] <= r_a[idx((i==0)?1:0, (j==2)?1:2)]
                                       * r_a[idx((i==2)?1:2, (j==0)?1:0)];
                    if (((i + j) & 1) == 1)
                        r_c[idx(i,j)] <= CofW'(r_p[2*idx(i,j)+1])
                                       - CofW'(r_p[2*idx(i,j)]);
                    else
                        r_c[idx(i,j)] <= CofW'(r_p[2*idx(i,j)])
                                       - CofW'(r_p[2*idx(i,j)+1]);
                end
            end
            r_a0  <= r_a[0:2];
            r_a0b <= r_a0;
        end
    end
    assign o_cof = r_c;
    assign o_a0  = r_a0b;
endmodule

// ----- rtl/mi3_det.sv -----
module mi3_det
    import mi3_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_en,
    input  t_cof  i_cof [9],
    input  t_elem i_a0 [3],
    output t_det  o_det,
    output t_cof  o_cof [9]
);
    logic signed [DetW-1:0] r_m [3];
    t_cof r_c1 [9];
    t_cof r_c2 [9];
    t_det r_det;
    logic signed [ElemW+31:0] r_lo [3];
    logic signed [ElemW+32:0] r_hi [3];
    t_cof r_c0 [9];

    // split at bit 32: low 32 bits of cofactor unsigned, rest signed
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_lo[k] <= i_a0[k] * $signed({1'b0, i_cof[k][31:0]});
                r_hi[k] <= i_a0[k] * $signed(i_cof[k][CofW-1:32]);
            end
            r_c0 <= i_cof;
            for (int k = 0; k < 3; k++)
                r_m[k] <= (DetW'(r_hi[k]) <<< 32) + DetW'(r_lo[k]);
            r_c1 <= r_c0;
            r_det <= r_m[0] + r_m[1] + r_m[2];
            r_c2 <= r_c1;
        end
    end
    assign o_det = r_det;
    assign o_cof = r_c2;
endmodule

// ----- rtl/mi3_div.sv -----
module mi3_div
    import mi3_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_en,
    input  t_det  i_det,
    input  t_cof  i_cof [9],
    output logic [QW-1:0] o_quo [9],
    output t_side o_side
);
    localparam int DmW = DetW;
    t_div_lane r_l [DivStages+1][9];
    logic [DmW-1:0] r_d [DivStages+1];
    t_side r_s [DivStages+1];

    function automatic t_div_lane step(input t_div_lane l, input logic [DmW-1:0] d);
        t_div_lane v;
        logic [NumW:0] t;
        v = l;
        for (int b = 0; b < BitsPerStage; b++) begin
            t = {v.rem, v.num[NumW-1]};
            v.num = v.num << 1;
            if (t >= {{(NumW+1-DmW){1'b0}}, d}) begin
                t = t - {{(NumW+1-DmW){1'b0}}, d};
                v.quo = {v.quo[QW-2:0], 1'b1};
            end else begin
                v.quo = {v.quo[QW-2:0], 1'b0};
            end
            v.rem = t[NumW-1:0];
        end
        return v;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d[0] <= i_det[DetW-1] ? DmW'(-i_det) : DmW'(i_det);
            r_s[0].singular <= (i_det == '0);
            for (int k = 0; k < 9; k++) begin
                // element (i,j) uses cofactor (j,i)
                r_s[0].neg[k] <= i_cof[(k%3)*3 + k/3][CofW-1] ^ i_det[DetW-1];
                r_l[0][k].rem <= '0;
                r_l[0][k].quo <= '0;
                r_l[0][k].num <= NumW'({(i_cof[(k%3)*3 + k/3][CofW-1]
                    ? CofW'(-i_cof[(k%3)*3 + k/3])
                    : CofW'(i_cof[(k%3)*3 + k/3])), {(2*FracB){1'b0}}});
            end
            for (int s = 0; s < DivStages; s++) begin
                r_d[s+1] <= r_d[s];
                r_s[s+1] <= r_s[s];
                for (int k = 0; k < 9; k++) begin
                    r_l[s+1][k] <= step(r_l[s][k], r_d[s]);
                end
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 9; k++) o_quo[k] = r_l[DivStages][k].quo;
    end
    assign o_side = r_s[DivStages];
endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
module tb;
    import mi3_pkg::*;

    localparam int NumRand   = 2000;
    localparam int CycleLimit = 600000;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [287:0] s_axis_tdata = '0;   // r0c0 r0c1 r0c2 r1c0 r1c1 r1c2 r2c0 r2c1 r2c2
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [295:0] m_axis_tdata;        // inv r0c0..r2c2, singular, saturated

    logic [287:0] matrix_q[$];
    bit           drain_q[$];          // hold until every inverse is back
    logic [295:0] inv_expected[$];
    int           mismatches = 0;
    int           results_seen = 0;
    int           cycles = 0;
    int           send_gap = 0;
    int           recv_gap = 0;
    int           hold_left = 0;
    bit           hold_done = 1'b0;
    bit           calm = 1'b0;

    matrix_inverse_3x3_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [295:0] calc_inverse(input logic [287:0] mat);
        logic signed [191:0] a[9];
        logic signed [191:0] cof[9];
        logic signed [191:0] det, num, den, q, lim;
        logic [295:0] res;
        logic [31:0]  mag;
        logic neg, sat;
        int r0, r1, c0, c1;
        for (int k = 0; k < 9; k++) begin
            a[k] = t_elem'(mat[k*32 +: 32]);
        end
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                r0 = (i == 0) ? 1 : 0;
                r1 = (i == 2) ? 1 : 2;
                c0 = (j == 0) ? 1 : 0;
                c1 = (j == 2) ? 1 : 2;
                cof[i*3+j] = a[r0*3+c0] * a[r1*3+c1] - a[r0*3+c1] * a[r1*3+c0];
                if ((i + j) % 2 == 1) cof[i*3+j] = -cof[i*3+j];
            end
        end
        det = a[0] * cof[0] + a[1] * cof[1] + a[2] * cof[2];
        res = '0;
        if (det == 0) begin
            res[288] = 1'b1;
            return res;
        end
        sat = 1'b0;
        lim = 192'sd1 <<< (ElemW - 1);
        den = (det < 0) ? -det : det;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                num = cof[j*3+i];
                neg = (num < 0) != (det < 0);
                if (num < 0) num = -num;
                q = (num <<< (2 * FracB)) / den;
                if (neg ? (q > lim) : (q >= lim)) begin
                    sat = 1'b1;
                    mag = neg ? 32'h8000_0000 : 32'h7fff_ffff;
                end else begin
                    mag = q[31:0];
                end
                if (neg) mag = -mag;
                res[(i*3+j)*32 +: 32] = mag;
            end
        end
        res[289] = sat;
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] rand_elem(input int kind);
        case (kind)
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 524288)) - 262144);
            2: return 32'($signed($urandom_range(0, 64)) - 32);
            default: return 32'($signed($urandom_range(0, 33554432)) - 16777216);
        endcase
    endfunction

    task automatic add_matrix(input logic [287:0] mat, input bit drain = 1'b0);
        matrix_q = {matrix_q, mat};
        drain_q = {drain_q, drain};
    endtask

    // driver
    always @(posedge i_clk) begin
        logic         nv;
        logic [287:0] nd;
        int           g;
        nv = s_axis_tvalid;
        nd = s_axis_tdata;
        g = send_gap;
        if (!i_rst_n) begin
            nv = 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                inv_expected = {inv_expected, calc_inverse(s_axis_tdata)};
                nv = 1'b0;
                g = pick_gap();
            end
            if (!nv) begin
                if (g > 0) begin
                    g--;
                end else if (matrix_q.size() > 0 &&
                             !(drain_q[0] && inv_expected.size() > 0)) begin
                    nd = matrix_q.pop_front();
                    void'(drain_q.pop_front());
                    nv = 1'b1;
                end
            end
        end
        s_axis_tvalid <= nv;
        s_axis_tdata  <= nd;
        send_gap = g;
    end

    // random gaps and one long hold-off on the result side, counted here
    always @(posedge i_clk) begin
        cycles++;
        if (cycles % 700 == 0) calm = ($urandom_range(0, 3) == 0);
        if (!hold_done && results_seen == 600) begin
            hold_done = 1'b1;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap--;
            m_axis_tready <= 1'b0;
        end else begin
            recv_gap = pick_gap();
            m_axis_tready <= (recv_gap == 0);
        end
        if (cycles > CycleLimit) begin
            $display("tb: errors");
            $finish;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        logic [295:0] want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (inv_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %h", m_axis_tdata);
            end else begin
                want = inv_expected.pop_front();
                for (int k = 0; k < 11; k++) begin
                    logic [31:0] e, g;
                    e = (k < 9) ? want[k*32 +: 32] : 32'(want[288 + k - 9]);
                    g = (k < 9) ? m_axis_tdata[k*32 +: 32] : 32'(m_axis_tdata[288 + k - 9]);
                    if (e !== g) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("word %0d field %0d: expected %h got %h",
                                     results_seen, k, e, g);
                    end
                end
            end
        end
    end

    initial begin
        logic [287:0] m;
        int kind;
        int total;
        // identity, zero, extremes, saturation, singular cases
        add_matrix({32'h0001_0000, 96'h0, 32'h0001_0000, 96'h0, 32'h0001_0000});
        add_matrix('0);
        add_matrix({9{32'h7fff_ffff}});
        add_matrix({9{32'h8000_0000}});
        add_matrix({32'h7fff_ffff, 32'h0, 32'h0, 32'h0, 32'h8000_0000, 32'h0,
                    32'h0, 32'h0, 32'h7fff_ffff});
        add_matrix({32'h1, 32'h0, 32'h0, 32'h0, 32'h1, 32'h0, 32'h0, 32'h0, 32'h1});
        add_matrix({32'hffff_ffff, 32'h0, 32'h0, 32'h0, 32'h1, 32'h0,
                    32'h0, 32'h0, 32'hffff_ffff});
        add_matrix({32'h0002_0000, 32'h0, 32'h0, 32'h0, 32'hfffe_0000, 32'h0,
                    32'h0, 32'h0, 32'h0000_8000});
        add_matrix({32'h0003_0000, 32'h0002_0000, 32'h0001_0000,
                    32'h0006_0000, 32'h0004_0000, 32'h0002_0000,
                    32'h0001_0000, 32'h0005_0000, 32'h0007_0000});
        add_matrix({32'h0000_0000, 32'h0001_0000, 32'h0000_0000,
                    32'h0000_0000, 32'h0000_0000, 32'h0001_0000,
                    32'h0001_0000, 32'h0000_0000, 32'h0000_0000});
        add_matrix({32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                    32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                    32'h8000_0000, 32'h7fff_ffff, 32'h0});
        add_matrix({32'hffff_0000, 32'h0000_8000, 32'h0001_0000,
                    32'h0002_0000, 32'hffff_8000, 32'h0000_4000,
                    32'h0000_1000, 32'h0003_0000, 32'hfffc_0000});
        for (int n = 0; n < NumRand; n++) begin
            kind = $urandom_range(0, 9);
            for (int k = 0; k < 9; k++) begin
                m[k*32 +: 32] = rand_elem(kind < 5 ? 1 : kind - 5);
            end
            // rank-deficient unless both picks match: repeat a row
            if ($urandom_range(0, 9) == 0) begin
                m[96*$urandom_range(0, 2) +: 96] = m[96*$urandom_range(0, 2) +: 96];
            end
            add_matrix(m, n == NumRand / 2);
        end
        total = matrix_q.size();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (results_seen >= total);
        repeat (100) @(posedge i_clk);
        if (mismatches == 0 && inv_expected.size() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end
endmodule

// ----- matrix_inverse_3x3_top.f -----
+incdir+rtl
rtl/mi3_pkg.sv
rtl/mi3_cof.sv
rtl/mi3_det.sv
rtl/mi3_div.sv
rtl/matrix_inverse_3x3_top.sv
verif/tb.sv
